// ===== hdl/hula_probe_flowlet_router_unit_assert.svh =====
// Assertion macros shared by the router RTL.
`ifndef HULA_PROBE_FLOWLET_ROUTER_UNIT_ASSERT_SVH
`define HULA_PROBE_FLOWLET_ROUTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HPFR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hpfr: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HPFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hpfr: next-cycle check failed");

`endif

// ===== hdl/hpfr_pkg.sv =====
// Types and constants of the probe and flowlet router.
`timescale 1ns / 1ps
package hpfr_pkg;

  // Input transaction payload
  typedef struct packed {
    logic        cmd;
    logic [3:0]  in_port;
    logic [31:0] dest_addr;
    logic [31:0] dest_mask;
    logic [31:0] probe_max_util;
    logic [47:0] probe_time;
    logic [15:0] pkt_bytes;
    logic [47:0] now_ticks;
    logic [31:0] flow_hash;
  } in_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [3:0]  out_port;
    logic        route_found;
    logic [31:0] util_out;
    logic [15:0] forward_ports;
    logic [47:0] probe_time_out;
    logic        table_full;
  } out_item_t;

  // Command codes
  localparam logic CMD_PROBE = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_IS_EDGE    = 3'd0,
    REG_TAU        = 3'd1,
    REG_FLOW_GAP   = 3'd2,
    REG_LOCAL_PFX  = 3'd3,
    REG_LOCAL_MASK = 3'd4,
    REG_LOCAL_PORT = 3'd5,
    REG_PORT_EN    = 3'd6
  } reg_idx_e;

  localparam int unsigned PADDR_W = 5;

  // Reset values
  localparam logic [31:0] TAU_RESET = 32'd1000;
  localparam logic [31:0] GAP_RESET = 32'd1000;

  // Per-packet overhead added to the data counter
  localparam logic [16:0] PKT_OVERHEAD = 17'd40;

  // Flowlet entry: valid, tag, port, time
  localparam int unsigned FLOW_ENTRY_W = 1 + 32 + 4 + 48;

  // Shared divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_PU_START,
    S_PU_DIV,
    S_PU_MUL1,
    S_PU_MUL2,
    S_PU_SUM,
    S_PU_FIN,
    S_P_M1,
    S_P_M2,
    S_P_SCAN,
    S_P_INS,
    S_D_SCAN,
    S_D_HASH,
    S_D_FRD,
    S_D_FDEC,
    S_DONE
  } state_e;

endpackage

// ===== hdl/hpfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hpfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/hpfr_div.sv =====
// Shared restoring divider: (hi * 2^32 + lo) / divisor, one bit per cycle.
`timescale 1ns / 1ps
module hpfr_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hpfr_pkg::div_req_t  req_i,
  output hpfr_pkg::div_rsp_t  rsp_o
);
  import hpfr_pkg::*;

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] lo_q, lo_d;
  logic [32:0] quot_q, quot_d;
  logic [32:0] shifted;
  logic        fits;

  // One long-division step
  assign shifted = {rem_q, lo_q[31]};
  assign fits    = shifted >= {1'b0, req_i.divisor};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    if (req_i.start) begin
      // hi never exceeds the divisor, so one subtract settles the top bit
      busy_d = 1'b1;
      cnt_d  = 6'd32;
      lo_d   = req_i.lo;
      if (req_i.hi >= req_i.divisor) begin
        rem_d  = req_i.hi - req_i.divisor;
        quot_d = 33'd1;
      end else begin
        rem_d  = req_i.hi;
        quot_d = 33'd0;
      end
    end else if (busy_q) begin
      if (cnt_q != 6'd0) begin
        cnt_d  = cnt_q - 6'd1;
        lo_d   = {lo_q[30:0], 1'b0};
        quot_d = {quot_q[31:0], fits};
        rem_d  = fits ? 32'(shifted - {1'b0, req_i.divisor}) : shifted[31:0];
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = busy_q && (cnt_q == 6'd0);
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== hdl/hula_probe_flowlet_router_unit.sv =====
// Top level: probe utilization tracking, best-path table and flowlet forwarding.
// Usage:
//  - Input channel in_valid_i / in_stall_o carries one probe (cmd 0) or data
//    packet (cmd 1) per transaction; output channel out_valid_o / out_stall_i
//    returns exactly one result transaction per input.
//  - The user must write registers over APB while the block is idle (unchecked).
//  - One item is processed at a time. A port counter update with decay runs
//    the shared divider and then the multiplier (low part, then high part);
//    without decay it skips both. Route lookups walk one entry per cycle.
//    The flowlet slot is the low hash bits when FLOWLET_ENTRIES is a power of
//    two, else the divider remainder.
//  - After reset the flowlet memory is cleared, one entry per cycle;
//    in_stall_o stays high meanwhile.
//  - A result waits in the output register while out_stall_i is high; the
//    next item may be accepted then, and it holds at its end until the
//    output register frees up.
`timescale 1ns / 1ps
`include "hula_probe_flowlet_router_unit_assert.svh"
module hula_probe_flowlet_router_unit #(
  parameter int unsigned ROUTE_ENTRIES   = 16,
  parameter int unsigned PORT_COUNT      = 16,
  parameter int unsigned FLOWLET_ENTRIES = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  hpfr_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output hpfr_pkg::out_item_t           out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hpfr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hpfr_pkg::*;

  localparam int unsigned PIW = $clog2(PORT_COUNT);
  localparam int unsigned RIW = ROUTE_ENTRIES > 1 ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int unsigned FIW = FLOWLET_ENTRIES > 1 ? $clog2(FLOWLET_ENTRIES) : 1;
  localparam logic [15:0] PORT_MASK =
    (PORT_COUNT >= 16) ? 16'hFFFF : 16'((32'd1 << PORT_COUNT) - 32'd1);
  localparam bit FLOW_POW2 = (FLOWLET_ENTRIES & (FLOWLET_ENTRIES - 1)) == 0;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic        is_edge_q;
  logic [31:0] tau_q, gap_q, lpfx_q, lmask_q;
  logic [3:0]  lport_q;
  logic [15:0] pen_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_edge_q <= 1'b0;
      tau_q     <= TAU_RESET;
      gap_q     <= GAP_RESET;
      lpfx_q    <= 32'd0;
      lmask_q   <= 32'd0;
      lport_q   <= 4'd0;
      pen_q     <= 16'd0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_IS_EDGE:    is_edge_q <= pwdata[0];
        REG_TAU:        tau_q     <= pwdata;
        REG_FLOW_GAP:   gap_q     <= pwdata;
        REG_LOCAL_PFX:  lpfx_q    <= pwdata;
        REG_LOCAL_MASK: lmask_q   <= pwdata;
        REG_LOCAL_PORT: lport_q   <= pwdata[3:0];
        REG_PORT_EN:    pen_q     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_idx)
      REG_IS_EDGE:    prdata = {31'd0, is_edge_q};
      REG_TAU:        prdata = tau_q;
      REG_FLOW_GAP:   prdata = gap_q;
      REG_LOCAL_PFX:  prdata = lpfx_q;
      REG_LOCAL_MASK: prdata = lmask_q;
      REG_LOCAL_PORT: prdata = {28'd0, lport_q};
      REG_PORT_EN:    prdata = {16'd0, pen_q};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // State
  state_e state_q, state_d;

  in_item_t    in_q;
  logic [3:0]  pu_port_q;
  logic [16:0] pu_bytes_q;
  logic [32:0] f_q;
  logic [48:0] p1_q;
  logic [64:0] p2_q;
  logic [48:0] u_q;
  logic [57:0] prod_q;
  logic [31:0] m_q;
  logic [31:0] uout_q;
  logic        allowed_q, any_q, free_q, found_q, full_q;
  logic [RIW-1:0] ri_q, free_idx_q;
  logic [3:0]  rport_q, oport_q;
  logic [FIW-1:0] slot_q, clr_q;
  logic        out_valid_q;
  out_item_t   out_q;

  // Route table
  logic [31:0] rt_net_q  [ROUTE_ENTRIES];
  logic [31:0] rt_mask_q [ROUTE_ENTRIES];
  logic [3:0]  rt_port_q [ROUTE_ENTRIES];
  logic [31:0] rt_util_q [ROUTE_ENTRIES];
  logic        rt_valid_q [ROUTE_ENTRIES];

  // Port counters
  logic [47:0] pt_util_q [PORT_COUNT];
  logic [47:0] pt_last_q [PORT_COUNT];
  logic        pt_seen_q [PORT_COUNT];

  // ---------------------------------------------------------------------------
  // Shared units
  div_req_t div_req;
  div_rsp_t div_rsp;

  hpfr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Flowlet memory
  logic                    ram_we;
  logic [FIW-1:0]          ram_waddr;
  logic [FLOW_ENTRY_W-1:0] ram_wdata, ram_rdata;

  hpfr_ram #(
    .WIDTH (FLOW_ENTRY_W),
    .DEPTH (FLOWLET_ENTRIES)
  ) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Common decodes
  logic           port_ok;
  logic [PIW-1:0] pidx;
  logic [47:0]    last_t, dt;
  logic           decay;
  logic [RIW-1:0] eidx;
  logic           rmatch, rlast;
  logic           in_acc, out_free;

  assign port_ok = {1'b0, pu_port_q} < 5'(PORT_COUNT);
  assign pidx    = pu_port_q[PIW-1:0];
  assign last_t  = pt_last_q[pidx];
  assign dt      = (in_q.now_ticks >= last_t) ? in_q.now_ticks - last_t : 48'd0;
  assign decay   = pt_seen_q[pidx] && (dt < {16'd0, tau_q});

  assign eidx   = ri_q;
  assign rmatch = rt_valid_q[eidx] &&
                  ((in_q.dest_addr & rt_mask_q[eidx]) ==
                   (rt_net_q[eidx] & rt_mask_q[eidx]));
  assign rlast  = ri_q == RIW'(ROUTE_ENTRIES - 1);

  assign in_stall_o = state_q != S_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Counter value of the port being updated
  logic [47:0] cnt;
  assign cnt = port_ok ? pt_util_q[pidx] : 48'd0;

  // Shared multiplier: low 16, then high 32 bits of the counter times the decay factor
  logic [31:0] mul_a;
  logic [64:0] mul_p;
  assign mul_a = (state_q == S_PU_MUL1) ? {16'd0, cnt[15:0]} : cnt[47:16];
  assign mul_p = mul_a * f_q;

  // Probe magnitude after rounding and clamping
  logic [57:0] rsum;
  logic [41:0] mr, mx;
  logic        is_local;
  assign rsum     = prod_q + 58'd32768;
  assign mr       = rsum[57:16];
  assign mx       = (mr > {10'd0, in_q.probe_max_util}) ? mr : {10'd0, in_q.probe_max_util};
  assign is_local = (in_q.dest_addr & lmask_q) == (lpfx_q & lmask_q);

  // Flowlet entry fields
  logic        fv;
  logic [31:0] ftag;
  logic [3:0]  fport;
  logic [47:0] ftime, fel;
  logic        fexp, fhit;
  assign {fv, ftag, fport, ftime} = ram_rdata;
  assign fel  = (in_q.now_ticks >= ftime) ? in_q.now_ticks - ftime : 48'd0;
  assign fexp = fv && (fel > {16'd0, gap_q});
  assign fhit = fv && (ftag == in_q.flow_hash);

  // Counter sums
  logic [64:0] psum;
  logic [49:0] usum;
  assign psum = p2_q + {32'd0, p1_q[48:16]};
  assign usum = {1'b0, u_q} + {17'd0, pu_bytes_q, 16'd0};

  // ---------------------------------------------------------------------------
  // Sequencer: next state and unit controls
  always_comb begin
    state_d        = state_q;
    div_req        = '0;
    div_req.divisor = tau_q;
    ram_we         = 1'b0;
    ram_waddr      = slot_q;
    ram_wdata      = {1'b1, in_q.flow_hash, rport_q, in_q.now_ticks};
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == FIW'(FLOWLET_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_data_i.cmd == CMD_PROBE) ? S_PU_START : S_D_SCAN;
        end
      end
      S_PU_START: begin
        if (!port_ok) begin
          state_d = (in_q.cmd == CMD_PROBE) ? S_P_M1 : S_DONE;
        end else if (decay) begin
          div_req.start = 1'b1;
          div_req.hi    = tau_q - dt[31:0];
          state_d       = S_PU_DIV;
        end else begin
          state_d = S_PU_FIN;
        end
      end
      S_PU_DIV:  if (div_rsp.done) state_d = S_PU_MUL1;
      S_PU_MUL1: state_d = S_PU_MUL2;
      S_PU_MUL2: state_d = S_PU_SUM;
      S_PU_SUM:  state_d = S_PU_FIN;
      S_PU_FIN:  state_d = (in_q.cmd == CMD_PROBE) ? S_P_M1 : S_DONE;
      S_P_M1:    state_d = S_P_M2;
      S_P_M2:    state_d = is_local ? S_DONE : S_P_SCAN;
      S_P_SCAN: begin
        if (rmatch && rt_port_q[eidx] != in_q.in_port && rt_util_q[eidx] <= m_q) begin
          state_d = S_DONE;
        end else if (rlast) begin
          state_d = S_P_INS;
        end
      end
      S_P_INS: state_d = S_DONE;
      S_D_SCAN: begin
        if (rmatch) begin
          if (FLOW_POW2) begin
            state_d = S_D_FRD;
          end else begin
            div_req.start   = 1'b1;
            div_req.lo      = in_q.flow_hash;
            div_req.divisor = 32'(FLOWLET_ENTRIES);
            state_d         = S_D_HASH;
          end
        end else if (rlast) begin
          state_d = S_DONE;
        end
      end
      S_D_HASH: begin
        div_req.divisor = 32'(FLOWLET_ENTRIES);
        if (div_rsp.done) state_d = S_D_FRD;
      end
      S_D_FRD: state_d = S_D_FDEC;
      S_D_FDEC: begin
        if (fhit) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, in_q.flow_hash, fexp ? rport_q : fport, in_q.now_ticks};
        end else if (!fv || fexp) begin
          ram_we = 1'b1;
        end
        state_d = S_PU_START;
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing counter and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + FIW'(1);
      end
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_q.out_port       <= oport_q;
      out_q.route_found    <= found_q;
      out_q.util_out       <= uout_q;
      out_q.forward_ports  <= allowed_q ? (pen_q & ~(16'd1 << in_q.in_port) & PORT_MASK)
                                        : 16'd0;
      out_q.probe_time_out <= (in_q.cmd == CMD_PROBE) ? in_q.probe_time : 48'd0;
      out_q.table_full     <= full_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Item datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        in_q       <= in_data_i;
        pu_port_q  <= in_data_i.in_port;
        pu_bytes_q <= {1'b0, in_data_i.pkt_bytes};
        oport_q    <= 4'd0;
        found_q    <= 1'b0;
        uout_q     <= 32'd0;
        full_q     <= 1'b0;
        allowed_q  <= 1'b0;
        any_q      <= 1'b0;
        free_q     <= 1'b0;
        ri_q       <= '0;
      end
      S_PU_START: u_q <= '0;
      S_PU_DIV:   f_q <= div_rsp.quot;
      S_PU_MUL1: begin
        p1_q <= mul_p[48:0];
      end
      S_PU_MUL2:  p2_q <= mul_p;
      S_PU_SUM:   u_q  <= psum[64:16];
      S_P_M1:     prod_q <= {cnt, 10'd0} - {6'd0, cnt, 4'd0} - {7'd0, cnt, 3'd0};
      S_P_M2: begin
        m_q <= (|mx[41:32]) ? 32'hFFFF_FFFF : mx[31:0];
        if (is_local) begin
          allowed_q <= in_q.in_port == lport_q;
        end else begin
          uout_q    <= (|mx[41:32]) ? 32'hFFFF_FFFF : mx[31:0];
          allowed_q <= !is_edge_q;
        end
      end
      S_P_SCAN: begin
        if (rmatch) begin
          any_q <= 1'b1;
          if (rt_port_q[eidx] != in_q.in_port && rt_util_q[eidx] <= m_q) begin
            uout_q <= rt_util_q[eidx];
          end
        end else if (!rt_valid_q[eidx] && !free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= eidx;
        end
        ri_q <= ri_q + RIW'(1);
      end
      S_P_INS: begin
        if (!any_q && !free_q) full_q <= 1'b1;
      end
      S_D_SCAN: begin
        if (rmatch) begin
          found_q <= 1'b1;
          rport_q <= rt_port_q[eidx];
          oport_q <= rt_port_q[eidx];
          // Power-of-two table: the slot is the low hash bits
          if (FLOW_POW2) slot_q <= FIW'(in_q.flow_hash & 32'(FLOWLET_ENTRIES - 1));
        end
        ri_q <= ri_q + RIW'(1);
      end
      S_D_HASH: slot_q <= div_rsp.rem[FIW-1:0];
      S_D_FDEC: begin
        pu_bytes_q <= {1'b0, in_q.pkt_bytes} + PKT_OVERHEAD;
        if (fhit && !fexp) begin
          oport_q   <= fport;
          pu_port_q <= fport;
        end else begin
          pu_port_q <= rport_q;
        end
        if (!fhit && fv && !fexp) full_q <= 1'b1;
      end
      default: ;
    endcase
  end

  // Route table writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ROUTE_ENTRIES; i++) begin
        rt_valid_q[i] <= 1'b0;
      end
    end else if (state_q == S_P_INS && !any_q && free_q) begin
      rt_valid_q[free_idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_P_SCAN && rmatch) begin
      if (rt_port_q[eidx] == in_q.in_port) begin
        rt_util_q[eidx] <= m_q;
      end else if (rt_util_q[eidx] > m_q) begin
        rt_util_q[eidx] <= m_q;
        rt_port_q[eidx] <= in_q.in_port;
      end
    end else if (state_q == S_P_INS && !any_q && free_q) begin
      rt_net_q[free_idx_q]  <= in_q.dest_addr;
      rt_mask_q[free_idx_q] <= in_q.dest_mask;
      rt_port_q[free_idx_q] <= in_q.in_port;
      rt_util_q[free_idx_q] <= m_q;
    end
  end

  // Port counter writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        pt_util_q[i] <= 48'd0;
        pt_seen_q[i] <= 1'b0;
      end
    end else if (state_q == S_PU_FIN && port_ok) begin
      pt_util_q[pidx] <= (|usum[49:48]) ? 48'hFFFF_FFFF_FFFF : usum[47:0];
      pt_seen_q[pidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PU_FIN && port_ok) begin
      pt_last_q[pidx] <= in_q.now_ticks;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  `HPFR_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_acc, state_q != S_IDLE)
  `HPFR_ASSERT_IMPL(a_div_done_expected, clk_i, rst_ni, div_rsp.done,
                    state_q == S_PU_DIV || state_q == S_D_HASH)
  `HPFR_ASSERT_IMPL(a_clear_blocks_input, clk_i, rst_ni, state_q == S_CLEAR, !in_acc)
  `HPFR_ASSERT_NEXT(a_done_delivers, clk_i, rst_ni,
                    state_q == S_DONE && !out_stall_i, out_valid_o)

endmodule
